/* rtl/sync_frame_parser_crc16_assert.svh */
// assertion macros for the frame parser top level
`ifndef SYNC_FRAME_PARSER_CRC16_ASSERT_SVH
`define SYNC_FRAME_PARSER_CRC16_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sfp_pkg.sv */
// shared types, constants and crc function for the frame parser
package sfp_pkg;

    localparam int HDR_BYTES = 9;
    localparam int HDR_IDX_W = 4;

    localparam logic [7:0]  SYNC_A        = 8'hEB;
    localparam logic [7:0]  SYNC_B        = 8'h90;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_END     = 1'b1;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

    typedef enum logic [7:0] {
        PH_HUNT0   = 8'b0000_0001,
        PH_HUNT1   = 8'b0000_0010,
        PH_HUNT2   = 8'b0000_0100,
        PH_HUNT3   = 8'b0000_1000,
        PH_HEADER  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRC_LO  = 8'b0100_0000,
        PH_CRC_HI  = 8'b1000_0000
    } sfp_phase_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  source_type;
        logic [7:0]  dest_type;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
        logic [1:0]  frame_status;
        logic        frame_last;
    } sfp_result_t;

    // crc16 msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[15] ^ b[7 - i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/sfp_parser.sv */
// frame parser state and per-item next-state and result logic
module sfp_parser import sfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] max_len,
    output logic        res_valid,
    output sfp_result_t res
);

    sfp_phase_t  phase_reg, phase_next;
    logic [7:0]  hdr_reg  [HDR_BYTES];
    logic [7:0]  hdr_next [HDR_BYTES];
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] crc_upd;
    logic [15:0] len_field;
    logic [HDR_IDX_W-1:0] pos;

    assign crc_upd   = crc16_byte(crc_reg, rx_byte);
    assign pos       = HDR_IDX_W'(HDR_BYTES) - count_reg[HDR_IDX_W-1:0];
    assign len_field = {rx_byte, hdr_reg[7]};

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        res_valid          = 1'b0;
        res.out_kind       = KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.frame_status   = STATUS_GOOD;
        res.frame_last     = 1'b0;

        unique case (phase_reg)
            PH_HUNT0: begin
                phase_next = (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
            end
            PH_HUNT1: begin
                phase_next = (rx_byte == SYNC_B) ? PH_HUNT2 :
                             (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
            end
            PH_HUNT2: begin
                phase_next = (rx_byte == SYNC_A) ? PH_HUNT3 : PH_HUNT0;
            end
            PH_HUNT3: begin
                if (rx_byte == SYNC_B) begin
                    phase_next = PH_HEADER;
                    count_next = 16'(HDR_BYTES);
                    crc_next   = CRC_INIT;
                end else begin
                    phase_next = (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_HEADER: begin
                for (int i = 0; i < HDR_BYTES; i++) begin
                    if (HDR_IDX_W'(i) == pos) begin
                        hdr_next[i] = rx_byte;
                    end
                end
                crc_next   = crc_upd;
                count_next = count_reg - 16'd1;
                if (count_reg == 16'd1) begin
                    // last header byte completes the length field
                    if (len_field > max_len) begin
                        res_valid        = 1'b1;
                        res.out_kind     = KIND_END;
                        res.frame_status = STATUS_LEN_ERR;
                        res.frame_last   = 1'b1;
                        phase_next       = PH_HUNT0;
                        count_next       = 16'd0;
                        crc_next         = CRC_INIT;
                        crc_lo_next      = 8'd0;
                    end else begin
                        count_next = len_field;
                        phase_next = (len_field == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next         = crc_upd;
                count_next       = count_reg - 16'd1;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                if (count_reg == 16'd1) begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                crc_lo_next = rx_byte;
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                res_valid        = 1'b1;
                res.out_kind     = KIND_END;
                res.frame_status = ({rx_byte, crc_lo_reg} == crc_reg) ?
                                   STATUS_GOOD : STATUS_CRC_ERR;
                res.frame_last   = 1'b1;
                phase_next       = PH_HUNT0;
                count_next       = 16'd0;
                crc_next         = CRC_INIT;
                crc_lo_next      = 8'd0;
            end
            default: begin
                phase_next = PH_HUNT0;
            end
        endcase

        // header fields as they stand after this byte
        res.source_type    = hdr_next[0];
        res.dest_type      = hdr_next[1];
        res.source_address = {hdr_next[3], hdr_next[2]};
        res.dest_address   = {hdr_next[5], hdr_next[4]};
        res.function_code  = hdr_next[6];
        res.payload_length = {hdr_next[8], hdr_next[7]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT0;
            count_reg  <= 16'd0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= 8'd0;
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= 8'd0;
            end
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

/* rtl/sfp_out_reg.sv */
// result register holding one item until the sink takes it
module sfp_out_reg import sfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        load_valid,
    input  sfp_result_t load_data,
    input  logic        m_ready,
    output logic        m_valid,
    output sfp_result_t m_data
);

    logic        valid_reg, valid_next;
    sfp_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = load_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* rtl/sync_frame_parser_crc16.sv */
// top level: sync hunt, header capture, payload pass-through, length and crc16 checks
// a result item enters the result register when its byte leaves the input register
// throughput: one byte per cycle, set by the single-byte crc update and phase logic;
//   a byte waits in the input register while the sink holds off a full result register
// reset (aresetn low, synchronous): hunting with no sync match, header zero,
//   crc 0xFFFF, max payload length 1024, both registers empty
module sync_frame_parser_crc16 import sfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max payload length
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_source_type,
    output logic [7:0]  m_dest_type,
    output logic [15:0] m_source_address,
    output logic [15:0] m_dest_address,
    output logic [7:0]  m_function_code,
    output logic [15:0] m_payload_length,
    output logic [1:0]  m_frame_status,
    output logic        m_frame_last
);

`include "sync_frame_parser_crc16_assert.svh"

    // configured payload limit
    logic [15:0] max_len_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // the byte in the input register is processed when the result slot is
    // free or is being emptied this cycle
    logic        advance;
    logic        res_valid;
    sfp_result_t res;
    sfp_result_t m_data;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // parse logic: state only moves when a byte is processed
    sfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register, parts the sink from the parse logic
    sfp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_valid (res_valid),
        .load_data  (res),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

    assign m_out_kind       = m_data.out_kind;
    assign m_payload_byte   = m_data.payload_byte;
    assign m_source_type    = m_data.source_type;
    assign m_dest_type      = m_data.dest_type;
    assign m_source_address = m_data.source_address;
    assign m_dest_address   = m_data.dest_address;
    assign m_function_code  = m_data.function_code;
    assign m_payload_length = m_data.payload_length;
    assign m_frame_status   = m_data.frame_status;
    assign m_frame_last     = m_data.frame_last;

    // an accepted byte always lands in the input register
    `SFP_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_valid && s_ready, in_valid_reg, "accepted item not registered")
    // a byte that cannot advance is held, not dropped
    `SFP_ASSERT_NEXT(a_stall_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "stalled item lost")
    // end reports and payload items carry consistent tags
    `SFP_ASSERT_NOW(a_kind_last, aclk, aresetn, m_valid, (m_out_kind == KIND_END) == m_frame_last, "kind and last disagree")
    // payload items carry good status
    `SFP_ASSERT_NOW(a_payload_status, aclk, aresetn, m_valid && (m_out_kind == KIND_PAYLOAD), m_frame_status == STATUS_GOOD, "payload item with nonzero status")

endmodule
